### sv/cdo_pkg.sv
// Shared types and constants for the calendar date day-offset block.
// Holds the input/result beat structs, the month length table and the span constants.
// No dependencies.
package cdo_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int MONTHS          = 12;
	localparam int SPAN_DAYS       = 1461;
	localparam int LEAP_MASK       = 3;

	typedef struct packed {
		logic [7:0]         year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic signed [15:0] delta;
	} item_t;

	typedef struct packed {
		logic [7:0] new_year;
		logic [3:0] new_month;
		logic [4:0] new_day;
	} result_t;

	function automatic logic [4:0] month_len(input logic [7:0] yr, input logic [3:0] mo);
		logic [4:0] n;
		unique case (mo)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
			4'd2:  n = ((yr & 8'(LEAP_MASK)) == 8'd0) ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

### sv/calendar_date_day_offset_top.sv
// Each item is walked one month step or one four-year span skip at a time until the day fits
// its month; done then strobes.
// One shared add unit applies one month length or one 1461-day span per cycle.
// Throughput: one item at a time; start is taken again in the cycle done is high.
// Reset (arst_n low, asynchronous) returns to idle and drops busy and done; no receiver stall.
// Depends on cdo_pkg.
module calendar_date_day_offset_top #(
	parameter int OFFSET_BITS = cdo_pkg::OFFSET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cdo_pkg::item_t   item,
	output logic             done,
	output cdo_pkg::result_t result
);

	localparam int CW = (OFFSET_BITS + 2 > 13) ? OFFSET_BITS + 2 : 13;

	typedef enum logic {ST_IDLE, ST_WALK} state_t;

	state_t               state_q;
	logic                 done_q;
	logic [7:0]           yr_q;
	logic [3:0]           mo_q;
	logic signed [CW-1:0] cur_q;

	logic [OFFSET_BITS-1:0] off;
	logic signed [CW-1:0]   cur_init;
	logic                   mo_valid;
	logic [4:0]             len_cur;
	logic [4:0]             len_prev;
	logic [7:0]             yr_next;
	logic [3:0]             mo_next;
	logic [7:0]             yr_prev;
	logic [3:0]             mo_prev;
	logic                   fwd;
	logic                   bwd;
	logic                   fwd_skip;
	logic                   bwd_skip;
	logic signed [CW-1:0]   addend;
	logic signed [CW-1:0]   cur_sum;
	logic signed [CW-1:0]   span;

	always_comb begin
		off      = OFFSET_BITS'($unsigned(item.delta));
		cur_init = CW'($signed(off)) + $signed(CW'(item.day));
		span     = CW'(cdo_pkg::SPAN_DAYS);
		mo_valid = (mo_q >= 4'd1) && (mo_q <= 4'(cdo_pkg::MONTHS));
		len_cur  = cdo_pkg::month_len(yr_q, mo_q);

		if (mo_q >= 4'(cdo_pkg::MONTHS)) begin
			mo_next = 4'd1;
			yr_next = yr_q + 8'd1;
		end else begin
			mo_next = mo_q + 4'd1;
			yr_next = yr_q;
		end
		if (mo_q <= 4'd1) begin
			mo_prev = 4'(cdo_pkg::MONTHS);
			yr_prev = yr_q - 8'd1;
		end else begin
			mo_prev = mo_q - 4'd1;
			yr_prev = yr_q;
		end
		len_prev = cdo_pkg::month_len(yr_prev, mo_prev);

		fwd      = cur_q > $signed(CW'(len_cur));
		bwd      = cur_q < $signed(CW'(1));
		fwd_skip = mo_valid && (cur_q > span);
		bwd_skip = mo_valid && (cur_q <= -span);

		priority if (fwd && fwd_skip) addend = -span;
		else if (fwd)                 addend = -$signed(CW'(len_cur));
		else if (bwd_skip)            addend = span;
		else                          addend = $signed(CW'(len_prev));
		cur_sum = cur_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						yr_q    <= item.year;
						mo_q    <= item.month;
						cur_q   <= cur_init;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					priority if (fwd && fwd_skip) begin
						cur_q <= cur_sum;
						yr_q  <= yr_q + 8'd4;
					end else if (fwd) begin
						cur_q <= cur_sum;
						yr_q  <= yr_next;
						mo_q  <= mo_next;
					end else if (bwd && bwd_skip) begin
						cur_q <= cur_sum;
						yr_q  <= yr_q - 8'd4;
					end else if (bwd) begin
						cur_q <= cur_sum;
						yr_q  <= yr_prev;
						mo_q  <= mo_prev;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy             = (state_q == ST_WALK);
	assign done             = done_q;
	assign result.new_year  = yr_q;
	assign result.new_month = mo_q;
	assign result.new_day   = cur_q[4:0];

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.new_month >= 4'd1 && result.new_month <= 4'(cdo_pkg::MONTHS)))
		else $error("result month out of range");
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cur_q >= $signed(CW'(1)) && cur_q <= $signed(CW'(len_cur))))
		else $error("result day outside month");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy)) else $error("done without a walk");
`endif

endmodule
